// File: sv/mp2d_pkg.sv
package mp2d_pkg;

  localparam int DATA_W      = 16;
  localparam int COORD_W     = 11;
  localparam int CNT_W       = 10;
  localparam int ROW_LIMIT   = 1024;
  localparam int MAX_COLS    = 1024;
  localparam int MAX_WINDOW  = 8;
  localparam int STORE_COLS  = MAX_COLS + MAX_WINDOW;
  localparam int STORE_DEPTH = MAX_WINDOW * STORE_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int DIV_STEPS   = COORD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);
  localparam int TDATA_W     = ((DATA_W + 2 * COORD_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    REG_IN_ROWS     = 3'd0,
    REG_IN_COLS     = 3'd1,
    REG_WINDOW_SIZE = 3'd2,
    REG_PAD_WIDTH   = 3'd3,
    REG_STEP_SIZE   = 3'd4,
    REG_PLANE_COUNT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] num;
    logic [3:0]         den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quo;
    logic [3:0]         rem;
  } div_rsp_t;

endpackage

// File: sv/mp2d_div.sv
module mp2d_div
  import mp2d_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [STEP_W-1:0]  cnt_q;
  logic               busy_q;
  logic [3:0]         rem_q;
  logic [3:0]         den_q;
  logic [COORD_W-1:0] num_q;
  logic [COORD_W-1:0] quo_q;
  logic               done_q;
  logic [4:0]         trial;
  logic               ge;

  // One quotient bit per cycle, restoring division.
  assign trial = {rem_q, num_q[COORD_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        den_q  <= req_i.den;
        num_q  <= req_i.num;
      end else if (busy_q) begin
        rem_q <= ge ? 4'(trial - {1'b0, den_q}) : trial[3:0];
        num_q <= {num_q[COORD_W-2:0], 1'b0};
        quo_q <= {quo_q[COORD_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: sv/max_pool_2d_stream_unit.sv
// Streaming 2-D max pooling of signed 16-bit pixels that arrive in raster order, plane after
// plane. After reset and after every write to one of the six configuration registers the
// block runs a setup of three divisions in its shared divider to find the pooled plane size,
// and accepts no pixel meanwhile. Each pixel is then taken, walked back to the first window
// that covers it, passed through a read and a write of the partial maximum store for each
// covering window (one port, registered read), and closed; no new pixel is taken until then.
// Results wait in a hold register and then an output register, so a stalled consumer holds
// the block only when a held result must move into an occupied output register.
module max_pool_2d_stream_unit
  import mp2d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,   // pixel
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // pooled_value, out_row, out_col, zero fill
  output logic               m_axis_tlast,   // last_of_run
  output logic [1:0]         m_axis_tuser    // plane_done, job_done
);

  typedef enum logic [2:0] {
    ST_SETUP, ST_SWAIT, ST_IDLE, ST_FIND, ST_READ, ST_WRITE, ST_FLUSH
  } state_e;

  state_e state_q;

  logic [10:0] in_rows_q, in_cols_q;
  logic [3:0]  window_q, step_q;
  logic [2:0]  pad_q;
  logic [15:0] planes_q;

  logic [10:0] rows_c, cols_c;
  logic [3:0]  k_c, s_c;
  logic [2:0]  p_c;
  logic [15:0] planes_c;

  always_comb begin
    rows_c   = (in_rows_q == '0) ? 11'd1 :
               (in_rows_q > 11'(ROW_LIMIT)) ? 11'(ROW_LIMIT) : in_rows_q;
    cols_c   = (in_cols_q == '0) ? 11'd1 :
               (in_cols_q > 11'(MAX_COLS)) ? 11'(MAX_COLS) : in_cols_q;
    k_c      = (window_q == '0) ? 4'd1 :
               (window_q > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : window_q;
    p_c      = ({1'b0, pad_q} > k_c - 4'd1) ? 3'(k_c - 4'd1) : pad_q;
    s_c      = (step_q == '0) ? k_c : step_q;
    planes_c = (planes_q == '0) ? 16'd1 : planes_q;
  end

  // Setup divisions: padded size minus window over the stride for rows and columns, then the padding over the stride.
  logic [11:0] rows_span, cols_span;
  logic        rows_neg, cols_neg;
  assign rows_span = {1'b0, rows_c} + 12'({p_c, 1'b0});
  assign cols_span = {1'b0, cols_c} + 12'({p_c, 1'b0});
  assign rows_neg  = rows_span < 12'(k_c);
  assign cols_neg  = cols_span < 12'(k_c);

  logic [1:0] phase_q;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  always_comb begin
    div_req.start = (state_q == ST_SETUP);
    div_req.den   = s_c;
    unique case (phase_q)
      2'd0:    div_req.num = rows_neg ? '0 : 11'(rows_span - 12'(k_c));
      2'd1:    div_req.num = cols_neg ? '0 : 11'(cols_span - 12'(k_c));
      default: div_req.num = 11'(p_c);
    endcase
  end

  mp2d_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic [COORD_W-1:0] orows_q, ocols_q;
  logic [COORD_W-1:0] q0_q;
  logic [3:0]         rem0_q;

  logic [CNT_W-1:0]   r_q, c_q;
  logic [15:0]        plane_q;
  logic [COORD_W-1:0] qr_q, qc_q;
  logic [3:0]         remr_q, remc_q;

  logic signed [DATA_W-1:0] pix_q;
  logic [COORD_W-1:0] fi_q, fj_q, ii_q, jj_q, jlo_q;
  logic [4:0]         fd_q, fe_q;
  logic               first_q, last_q;
  logic signed [DATA_W-1:0] rd_q;

  logic [COORD_W-1:0] R, C, ihi, jhi;
  logic [4:0]         fd_next, fe_next;
  logic               step_r, step_c, rows_ok, cols_ok;

  assign R = 11'(r_q) + 11'(p_c);
  assign C = 11'(c_q) + 11'(p_c);
  assign ihi = (qr_q > orows_q - 1'b1) ? orows_q - 1'b1 : qr_q;
  assign jhi = (qc_q > ocols_q - 1'b1) ? ocols_q - 1'b1 : qc_q;

  // Walk back from the last window that starts at or before this pixel.
  assign fd_next = fd_q + 5'(s_c);
  assign fe_next = fe_q + 5'(s_c);
  assign step_r  = (fi_q != '0) && (fd_next <= 5'(k_c - 4'd1));
  assign step_c  = (fj_q != '0) && (fe_next <= 5'(k_c - 4'd1));
  assign rows_ok = (orows_q != '0) && (remr_q < k_c) && (fi_q <= ihi);
  assign cols_ok = (ocols_q != '0) && (remc_q < k_c) && (fj_q <= jhi);

  // Window bounds for the current pair of indices.
  logic [14:0] is_w, js_w, fr_w, fc_w, lr_w, lc_w, rmax, cmax;
  logic        first_w, last_w;
  always_comb begin
    is_w    = 15'(ii_q) * 15'(s_c);
    js_w    = 15'(jj_q) * 15'(s_c);
    fr_w    = (is_w > 15'(p_c)) ? is_w : 15'(p_c);
    fc_w    = (js_w > 15'(p_c)) ? js_w : 15'(p_c);
    rmax    = 15'(p_c) + 15'(rows_c) - 15'd1;
    cmax    = 15'(p_c) + 15'(cols_c) - 15'd1;
    lr_w    = (is_w + 15'(k_c) - 15'd1 < rmax) ? is_w + 15'(k_c) - 15'd1 : rmax;
    lc_w    = (js_w + 15'(k_c) - 15'd1 < cmax) ? js_w + 15'(k_c) - 15'd1 : cmax;
    first_w = (15'(R) == fr_w) && (15'(C) == fc_w);
    last_w  = (15'(R) == lr_w) && (15'(C) == lc_w);
  end

  logic [ADDR_W-1:0] addr;
  assign addr = ADDR_W'(ii_q[SLOT_W-1:0]) * ADDR_W'(STORE_COLS) + ADDR_W'(jj_q);

  logic signed [DATA_W-1:0] new_val;
  assign new_val = first_q ? pix_q : ((pix_q > rd_q) ? pix_q : rd_q);

  // Held result: it is known to be the last of the run only once the run ends.
  logic                     hv_q, hpd_q, hjd_q;
  logic signed [DATA_W-1:0] hval_q;
  logic [COORD_W-1:0]       hrow_q, hcol_q;
  logic                     pd_w, jd_w;
  logic                     slot_free, write_go, mem_we;
  assign pd_w      = (ii_q == orows_q - 1'b1) && (jj_q == ocols_q - 1'b1);
  assign jd_w      = pd_w && ({1'b0, plane_q} + 17'd1 >= {1'b0, planes_c});
  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign write_go  = !(last_q && hv_q && !slot_free);
  assign mem_we    = (state_q == ST_WRITE) && write_go;

  logic signed [DATA_W-1:0] store_mem [STORE_DEPTH];
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[addr] <= new_val;
    end
    if (state_q == ST_READ) begin
      rd_q <= store_mem[addr];
    end
  end

  logic                     ov_q, olast_q, opd_q, ojd_q;
  logic signed [DATA_W-1:0] oval_q;
  logic [COORD_W-1:0]       orow_q, ocol_q;

  // A configuration write freezes the sequencer, so no pixel is taken in that cycle.
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_we_i;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = TDATA_W'({ocol_q, orow_q, oval_q});
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = {ojd_q, opd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SETUP;
      phase_q   <= '0;
      in_rows_q <= 11'd1;
      in_cols_q <= 11'd1;
      window_q  <= 4'd2;
      pad_q     <= '0;
      step_q    <= '0;
      planes_q  <= 16'd1;
      r_q       <= '0;
      c_q       <= '0;
      plane_q   <= '0;
      hv_q      <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IN_ROWS:     in_rows_q <= cfg_data_i[10:0];
          REG_IN_COLS:     in_cols_q <= cfg_data_i[10:0];
          REG_WINDOW_SIZE: window_q  <= cfg_data_i[3:0];
          REG_PAD_WIDTH:   pad_q     <= cfg_data_i[2:0];
          REG_STEP_SIZE:   step_q    <= cfg_data_i[3:0];
          REG_PLANE_COUNT: planes_q  <= cfg_data_i;
          default: ;
        endcase
        if (cfg_idx_i <= REG_PLANE_COUNT) begin
          state_q <= ST_SETUP;
          phase_q <= '0;
          r_q     <= '0;
          c_q     <= '0;
          plane_q <= '0;
        end
      end else begin
        unique case (state_q)
          ST_SETUP: state_q <= ST_SWAIT;
          ST_SWAIT: begin
            if (div_rsp.done) begin
              unique case (phase_q)
                2'd0: begin
                  orows_q <= rows_neg ? '0 : div_rsp.quo + 1'b1;
                  phase_q <= 2'd1;
                  state_q <= ST_SETUP;
                end
                2'd1: begin
                  ocols_q <= cols_neg ? '0 : div_rsp.quo + 1'b1;
                  phase_q <= 2'd2;
                  state_q <= ST_SETUP;
                end
                default: begin
                  q0_q    <= div_rsp.quo;
                  rem0_q  <= div_rsp.rem;
                  qr_q    <= div_rsp.quo;
                  remr_q  <= div_rsp.rem;
                  qc_q    <= div_rsp.quo;
                  remc_q  <= div_rsp.rem;
                  state_q <= ST_IDLE;
                end
              endcase
            end
          end
          ST_IDLE: begin
            if (s_axis_tvalid) begin
              pix_q   <= s_axis_tdata;
              fi_q    <= qr_q;
              fd_q    <= 5'(remr_q);
              fj_q    <= qc_q;
              fe_q    <= 5'(remc_q);
              state_q <= ST_FIND;
            end
          end
          ST_FIND: begin
            if (step_r) begin
              fi_q <= fi_q - 1'b1;
              fd_q <= fd_next;
            end
            if (step_c) begin
              fj_q <= fj_q - 1'b1;
              fe_q <= fe_next;
            end
            if (!step_r && !step_c) begin
              ii_q    <= fi_q;
              jj_q    <= fj_q;
              jlo_q   <= fj_q;
              state_q <= (rows_ok && cols_ok) ? ST_READ : ST_FLUSH;
            end
          end
          ST_READ: begin
            first_q <= first_w;
            last_q  <= last_w;
            state_q <= ST_WRITE;
          end
          ST_WRITE: begin
            if (write_go) begin
              if (last_q) begin
                if (hv_q) begin
                  ov_q    <= 1'b1;
                  oval_q  <= hval_q;
                  orow_q  <= hrow_q;
                  ocol_q  <= hcol_q;
                  olast_q <= 1'b0;
                  opd_q   <= hpd_q;
                  ojd_q   <= hjd_q;
                end
                hv_q   <= 1'b1;
                hval_q <= new_val;
                hrow_q <= ii_q;
                hcol_q <= jj_q;
                hpd_q  <= pd_w;
                hjd_q  <= jd_w;
              end
              if (jj_q < jhi) begin
                jj_q    <= jj_q + 1'b1;
                state_q <= ST_READ;
              end else if (ii_q < ihi) begin
                ii_q    <= ii_q + 1'b1;
                jj_q    <= jlo_q;
                state_q <= ST_READ;
              end else begin
                state_q <= ST_FLUSH;
              end
            end
          end
          ST_FLUSH: begin
            if (!hv_q || slot_free) begin
              if (hv_q) begin
                ov_q    <= 1'b1;
                oval_q  <= hval_q;
                orow_q  <= hrow_q;
                ocol_q  <= hcol_q;
                olast_q <= 1'b1;
                opd_q   <= hpd_q;
                ojd_q   <= hjd_q;
                hv_q    <= 1'b0;
              end
              state_q <= ST_IDLE;
              if (11'(c_q) + 11'd1 >= cols_c) begin
                c_q    <= '0;
                qc_q   <= q0_q;
                remc_q <= rem0_q;
                if (11'(r_q) + 11'd1 >= rows_c) begin
                  r_q    <= '0;
                  qr_q   <= q0_q;
                  remr_q <= rem0_q;
                  plane_q <= ({1'b0, plane_q} + 17'd1 >= {1'b0, planes_c}) ?
                             '0 : plane_q + 1'b1;
                end else begin
                  r_q <= r_q + 1'b1;
                  if (remr_q + 4'd1 == s_c) begin
                    qr_q   <= qr_q + 1'b1;
                    remr_q <= '0;
                  end else begin
                    remr_q <= remr_q + 4'd1;
                  end
                end
              end else begin
                c_q <= c_q + 1'b1;
                if (remc_q + 4'd1 == s_c) begin
                  qc_q   <= qc_q + 1'b1;
                  remc_q <= '0;
                end else begin
                  remc_q <= remc_q + 4'd1;
                end
              end
            end
          end
          default: state_q <= ST_SETUP;
        endcase
      end
    end
  end

endmodule

// File: sv/mp2d_checker.sv
module mp2d_checker
  import mp2d_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast,
  input logic [1:0]         m_axis_tuser
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A pixel is worked on alone: no second transaction right after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on two consecutive cycles");

  // The final window of a plane is the last result of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("plane end without run end");

  // The end of the job is also the end of a plane.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("job end without plane end");

endmodule

bind max_pool_2d_stream_unit mp2d_checker u_mp2d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
